// ----- design/htspd_pkg.sv -----
// ----------------------------------------------------------------------------
// htspd_pkg
// Shared types, constants and helpers for the sensor poll sequencer and
// frame decoder.
// ----------------------------------------------------------------------------
package htspd_pkg;

    // Millisecond counter width (12..32)
    localparam int CNT_W = 16;
    // Width used to compare the counter against the 16-bit thresholds
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_AFTER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_AFTER  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE       = 8'd3;

    // Register reset values
    localparam logic [9:0]  TICK_STEP_RST   = 10'd10;
    localparam logic [15:0] START_AFTER_RST = 16'd10;
    localparam logic [15:0] READ_AFTER_RST  = 16'd150;
    localparam logic [15:0] CYCLE_RST       = 16'd2000;

    // Frame layout and checks
    localparam int          FRAME_DATA  = 6;
    localparam int          POS_W       = 3;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  STATUS_MASK = 8'h98;
    localparam logic [7:0]  STATUS_WANT = 8'h18;

    // Scaling
    localparam logic [13:0] HUM_SCALE    = 14'd10000;
    localparam logic [14:0] TEMP_SCALE   = 15'd20000;
    localparam logic [15:0] TEMP_OFFSET  = 16'd5000;
    localparam int          RAW_W        = 20;

    // Input kind carried in s_tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MEASURE = 2'd1,
        PH_READ    = 2'd2,
        PH_HOLD    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_REQUEST = 3'd2,
        EV_VALID   = 3'd3,
        EV_REJECT  = 3'd4
    } event_t;

    typedef struct packed {
        logic [9:0]  tick_step;
        logic [15:0] start_after;
        logic [15:0] read_after;
        logic [15:0] cycle;
    } cfg_t;

    typedef logic [FRAME_DATA-1:0][7:0] frame_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_hum;
        logic [RAW_W-1:0] raw_temp;
        logic [13:0]      hum_centi;
        logic [14:0]      temp_centi;
    } meas_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/humidity_temp_sensor_poll_decode.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_sensor_poll_decode
// Sensor poll sequencer and measurement frame decoder: timer ticks drive the
// phase, received bytes build a CRC-checked frame that is scaled to
// hundredths.
//
//  Channel   Direction  Handshake              Content
//  s_*       in         s_tvalid / s_tready    tick (tuser 0) or rx byte
//  m_*       out        m_tvalid / m_tready    one result per input item
//  cfg_*     in         cfg_valid / cfg_ready  register index and data
//
// Each item is held in an input register, decoded combinationally and written
// to the result register: one item per cycle while m_ is not stalled.
// The input register refills while a result waits, so a stall on m_ stops
// s_ only once both registers are full. cfg_ready is always high.
// aresetn is synchronous; no clearing pass, the frame store needs no reset.
// ----------------------------------------------------------------------------
module humidity_temp_sensor_poll_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                          s_tuser,   // [0] action
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [71:0]                         m_tdata,   // [19:0] raw_humidity,
                                                           // [39:20] raw_temperature,
                                                           // [53:40] humidity_centi,
                                                           // [68:54] temperature_centi,
                                                           // [71:69] zero
    output logic [2:0]                          m_tuser,   // [2:0] event_kind
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [htspd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htspd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    htspd_pkg::cfg_t    cfg;
    htspd_pkg::event_t  item_event;
    htspd_pkg::frame_t  frame;
    htspd_pkg::meas_t   meas;

    logic               in_valid_reg;
    logic               in_action_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    htspd_pkg::event_t  out_kind_reg;
    htspd_pkg::meas_t   out_meas_reg;
    logic               advance;

    assign cfg_ready = 1'b1;

    // Move the held item into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    htspd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    htspd_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_go     (advance),
        .item_action (in_action_reg),
        .item_byte   (in_byte_reg),
        .item_event  (item_event),
        .frame       (frame)
    );

    htspd_scale u_scale (
        .frame (frame),
        .meas  (meas)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser[0];
            in_byte_reg   <= s_tdata;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg <= item_event;
            // data fields only carry meaning for a valid measurement
            out_meas_reg <= (item_event == htspd_pkg::EV_VALID) ? meas : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_meas_reg.temp_centi, out_meas_reg.hum_centi,
                       out_meas_reg.raw_temp, out_meas_reg.raw_hum};

    // Data fields are zero unless the result is a valid measurement
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != htspd_pkg::EV_VALID) |-> (m_tdata == '0))
        else $error("data fields set on a non-measurement result");

    // Input stalls only with both registers full and the result stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // A held item that cannot advance stays held
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held item lost");

    // Scaled humidity stays below 100.00 percent
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == htspd_pkg::EV_VALID) |-> (m_tdata[53:40] <= 14'd9999))
        else $error("humidity out of range");

endmodule

// ----- design/htspd_cfg.sv -----
// ----------------------------------------------------------------------------
// htspd_cfg
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module htspd_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [htspd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htspd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output htspd_pkg::cfg_t                   cfg
);

    htspd_pkg::cfg_t cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_step   <= htspd_pkg::TICK_STEP_RST;
            cfg_reg.start_after <= htspd_pkg::START_AFTER_RST;
            cfg_reg.read_after  <= htspd_pkg::READ_AFTER_RST;
            cfg_reg.cycle       <= htspd_pkg::CYCLE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                htspd_pkg::REG_TICK_STEP:   cfg_reg.tick_step   <= cfg_data[9:0];
                htspd_pkg::REG_START_AFTER: cfg_reg.start_after <= cfg_data;
                htspd_pkg::REG_READ_AFTER:  cfg_reg.read_after  <= cfg_data;
                htspd_pkg::REG_CYCLE:       cfg_reg.cycle       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/htspd_seq.sv -----
// ----------------------------------------------------------------------------
// htspd_seq
// Poll sequencer: phase, millisecond counter, frame capture and CRC check.
// Gives the event kind of the current item and the stored frame bytes.
// ----------------------------------------------------------------------------
module htspd_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  htspd_pkg::cfg_t         cfg,
    input  logic                    item_go,
    input  logic                    item_action,
    input  logic [7:0]              item_byte,
    output htspd_pkg::event_t       item_event,
    output htspd_pkg::frame_t       frame
);

    htspd_pkg::phase_t              phase_reg, phase_next;
    logic [htspd_pkg::CNT_W-1:0]    elapsed_reg, elapsed_next;
    logic [htspd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]                     crc_reg, crc_next;
    htspd_pkg::frame_t              frame_reg;

    logic [htspd_pkg::CNT_W-1:0]    elapsed_add;
    logic [htspd_pkg::CMP_W-1:0]    elapsed_cmp;
    logic                           over_start, over_read, over_cycle;
    logic                           data_byte;
    logic                           frame_ok;

    // Counter advance and threshold compares
    assign elapsed_add = elapsed_reg + htspd_pkg::CNT_W'(cfg.tick_step);
    assign elapsed_cmp = htspd_pkg::CMP_W'(elapsed_add);
    assign over_start  = elapsed_cmp > htspd_pkg::CMP_W'(cfg.start_after);
    assign over_read   = elapsed_cmp > htspd_pkg::CMP_W'(cfg.read_after);
    assign over_cycle  = elapsed_cmp > htspd_pkg::CMP_W'(cfg.cycle);

    assign data_byte = pos_reg < htspd_pkg::POS_W'(htspd_pkg::FRAME_DATA);
    assign frame_ok  = (crc_reg == item_byte) &&
                       ((frame_reg[0] & htspd_pkg::STATUS_MASK) == htspd_pkg::STATUS_WANT);

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        if (item_action == htspd_pkg::ACT_TICK) begin
            elapsed_next = elapsed_add;
            case (phase_reg)
                htspd_pkg::PH_IDLE: begin
                    if (over_start) phase_next = htspd_pkg::PH_MEASURE;
                end
                htspd_pkg::PH_MEASURE: begin
                    if (over_read) begin
                        phase_next = htspd_pkg::PH_READ;
                        pos_next   = '0;
                        crc_next   = htspd_pkg::CRC_INIT;
                    end
                end
                default: begin
                    // read timeout or end of hold
                    if (over_cycle) begin
                        phase_next   = htspd_pkg::PH_IDLE;
                        elapsed_next = '0;
                        pos_next     = '0;
                    end
                end
            endcase
        end else if (phase_reg == htspd_pkg::PH_READ) begin
            if (data_byte) begin
                crc_next = htspd_pkg::crc_feed(crc_reg, item_byte);
                pos_next = pos_reg + 1'b1;
            end else begin
                phase_next = htspd_pkg::PH_HOLD;
                pos_next   = '0;
            end
        end
    end

    // Event of the current item
    always_comb begin
        item_event = htspd_pkg::EV_NONE;
        if (item_action == htspd_pkg::ACT_TICK) begin
            case (phase_reg)
                htspd_pkg::PH_IDLE:    if (over_start) item_event = htspd_pkg::EV_START;
                htspd_pkg::PH_MEASURE: if (over_read)  item_event = htspd_pkg::EV_REQUEST;
                default: ;
            endcase
        end else if (phase_reg == htspd_pkg::PH_READ && !data_byte) begin
            item_event = frame_ok ? htspd_pkg::EV_VALID : htspd_pkg::EV_REJECT;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= htspd_pkg::PH_IDLE;
            elapsed_reg <= '0;
            pos_reg     <= '0;
            crc_reg     <= htspd_pkg::CRC_INIT;
        end else if (item_go) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
        end
    end

    // Frame byte store, no reset
    always_ff @(posedge aclk) begin
        if (item_go && item_action == htspd_pkg::ACT_BYTE &&
            phase_reg == htspd_pkg::PH_READ && data_byte) begin
            frame_reg[pos_reg] <= item_byte;
        end
    end

    assign frame = frame_reg;

endmodule

// ----- design/htspd_scale.sv -----
// ----------------------------------------------------------------------------
// htspd_scale
// Frame field extraction and fixed-point scaling to hundredths.
// ----------------------------------------------------------------------------
module htspd_scale (
    input  htspd_pkg::frame_t   frame,
    output htspd_pkg::meas_t    meas
);

    logic [htspd_pkg::RAW_W-1:0] raw_hum;
    logic [htspd_pkg::RAW_W-1:0] raw_temp;
    logic [33:0]                 hum_prod;
    logic [34:0]                 temp_prod;
    logic [15:0]                 temp_diff;

    // 20-bit raw fields; byte 3 is split between them
    assign raw_hum  = {frame[1], frame[2], frame[3][7:4]};
    assign raw_temp = {frame[3][3:0], frame[4], frame[5]};

    // Scale and floor
    assign hum_prod  = 34'(raw_hum) * 34'(htspd_pkg::HUM_SCALE);
    assign temp_prod = 35'(raw_temp) * 35'(htspd_pkg::TEMP_SCALE);
    assign temp_diff = {1'b0, temp_prod[34:20]} - htspd_pkg::TEMP_OFFSET;

    assign meas.raw_hum    = raw_hum;
    assign meas.raw_temp   = raw_temp;
    assign meas.hum_centi  = hum_prod[33:20];
    assign meas.temp_centi = temp_diff[14:0];

endmodule
